// ===== rtl/awlm_pkg.sv =====
// Package for the allocation wait latency monitor.
// Holds the stream field layouts, register indexes and command codes.
// No dependencies.
`default_nettype none

package awlm_pkg;

   localparam int REQ_TDATA_W = 128;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 160;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int NUM_CLASS   = 3;

   // commands, carried in req_tuser
   localparam logic [1:0] CMD_WAIT      = 2'd0;
   localparam logic [1:0] CMD_READ_STAT = 2'd1;
   localparam logic [1:0] CMD_READ_RING = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOG_ENABLE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIG_ENABLE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_THRESH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_THRESH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LOG_THRESH   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIG_THRESH  = 3'd6;

   localparam logic [31:0] HIGH_THRESH_RESET = 32'd500;
   localparam logic [31:0] LOW_THRESH_RESET  = 32'd100;
   localparam logic [31:0] LOG_THRESH_RESET  = 32'd1000;
   localparam logic [31:0] TRIG_THRESH_RESET = 32'd10000;

   // statistic select codes
   localparam logic [1:0] STAT_MAX_WAIT   = 2'd0;
   localparam logic [1:0] STAT_MAX_ORDER  = 2'd1;
   localparam logic [1:0] STAT_HIGH_COUNT = 2'd2;
   localparam logic [1:0] STAT_LOW_COUNT  = 2'd3;
   localparam logic [3:0] SEL_COUNTER     = 4'd12;

   // input item fields, lowest bit first is the last member
   typedef struct packed {
      logic [1:0]  pad;
      logic [3:0]  select;
      logic [29:0] time_nanoseconds;
      logic [31:0] time_seconds;
      logic [21:0] task_id;
      logic        is_foreground;
      logic        is_urgent;
      logic [3:0]  alloc_order;
      logic [31:0] wait_ms;
   } req_data_type;

   // result item fields
   typedef struct packed {
      logic        pad;
      logic [31:0] rec_wait_ms;
      logic [29:0] rec_nanoseconds;
      logic [31:0] rec_seconds;
      logic [3:0]  rec_order;
      logic [21:0] rec_task_id;
      logic [31:0] stat_value;
      logic [3:0]  record_slot;
      logic        recorded;
      logic        trigger_alert;
      logic        log_alert;
   } rsp_data_type;

   typedef struct packed {
      logic [21:0] task_id;
      logic [3:0]  order;
      logic [31:0] seconds;
      logic [29:0] nanoseconds;
      logic [31:0] wait_ms;
   } ring_entry_type;

   // per-class update request
   typedef struct packed {
      logic        update;
      logic        is_high;
      logic        is_low;
      logic [31:0] wait_ms;
      logic [3:0]  order;
   } class_upd_type;

   typedef struct packed {
      logic [31:0] max_wait;
      logic [3:0]  max_order;
      logic [31:0] high_count;
      logic [31:0] low_count;
   } class_stat_type;

endpackage

`default_nettype wire

// ===== rtl/alloc_wait_latency_monitor_core.sv =====
// Allocation wait latency monitor, top level.
// rsp_tvalid is registered: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle; backpressure on rsp stalls the input register.
// Reset (synchronous, active high): class statistics, record counter and ring
// valid bits clear at once; thresholds return to 500/100/1000/10000 ms.
// Depends on awlm_pkg, awlm_class, awlm_ring.
`default_nettype none

module alloc_wait_latency_monitor_core #(
   parameter int RING_DEPTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   // slave side; tdata: wait_ms, alloc_order, is_urgent, is_foreground,
   // task_id, time_seconds, time_nanoseconds, select, zero pad
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [awlm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: cmd
   input  wire  [awlm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // master side; tdata: log_alert, trigger_alert, recorded, record_slot,
   // stat_value, rec_task_id, rec_order, rec_seconds, rec_nanoseconds,
   // rec_wait_ms, zero pad
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [awlm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // configuration write port
   input  wire                                csr_we,
   input  wire  [awlm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [awlm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import awlm_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int KEEP   = (RING_DEPTH < 16) ? RING_DEPTH : 16;
   localparam int IDX_W  = $clog2(KEEP);

   // configuration
   logic        enable_ff, log_enable_ff, trig_enable_ff;
   logic [31:0] high_th_ff, low_th_ff, log_th_ff, trig_th_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         log_enable_ff  <= 1'b0;
         trig_enable_ff <= 1'b0;
         high_th_ff     <= HIGH_THRESH_RESET;
         low_th_ff      <= LOW_THRESH_RESET;
         log_th_ff      <= LOG_THRESH_RESET;
         trig_th_ff     <= TRIG_THRESH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENABLE:      enable_ff      <= csr_wdata[0];
            REG_LOG_ENABLE:  log_enable_ff  <= csr_wdata[0];
            REG_TRIG_ENABLE: trig_enable_ff <= csr_wdata[0];
            REG_HIGH_THRESH: high_th_ff     <= csr_wdata;
            REG_LOW_THRESH:  low_th_ff      <= csr_wdata;
            REG_LOG_THRESH:  log_th_ff      <= csr_wdata;
            REG_TRIG_THRESH: trig_th_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register and handshake
   logic         in_valid_ff, rsp_valid_ff, advance;
   req_data_type in_data_ff;
   logic [1:0]   in_cmd_ff;
   rsp_data_type rsp_data_ff, rsp_data_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_data_type'(req_tdata);
         in_cmd_ff  <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // event evaluation
   logic do_event, is_high, is_low, do_record;

   assign do_event  = in_valid_ff && advance && enable_ff && (in_cmd_ff == CMD_WAIT);
   assign is_high   = in_data_ff.wait_ms >= high_th_ff;
   assign is_low    = in_data_ff.wait_ms >= low_th_ff;
   assign do_record = do_event && is_low;

   // class statistics: urgent, foreground, all
   class_upd_type  upd [NUM_CLASS];
   class_stat_type stat [NUM_CLASS];

   for (genvar c = 0; c < NUM_CLASS; c++) begin : g_class
      always_comb begin
         upd[c].is_high = is_high;
         upd[c].is_low  = is_low;
         upd[c].wait_ms = in_data_ff.wait_ms;
         upd[c].order   = in_data_ff.alloc_order;
         case (c)
            0:       upd[c].update = do_event && in_data_ff.is_urgent;
            1:       upd[c].update = do_event && in_data_ff.is_foreground;
            default: upd[c].update = do_event;
         endcase
      end

      awlm_class u_class (
         .clock (clock),
         .reset (reset),
         .upd   (upd[c]),
         .stat  (stat[c])
      );
   end

   // record counter and its residue modulo the ring depth
   logic [31:0]       counter_ff, counter_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   assign counter_in = counter_ff + 32'd1;
   always_comb begin
      if (counter_in == '0) begin
         slot_in = '0;
      end else if (slot_ff == SLOT_W'(RING_DEPTH - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         slot_ff    <= '0;
      end else if (do_record) begin
         counter_ff <= counter_in;
         slot_ff    <= slot_in;
      end
   end

   // ring storage
   ring_entry_type wr_entry, rd_entry;
   logic           ring_wr;

   assign ring_wr = do_record && ((SLOT_W + 1)'(slot_in) < (SLOT_W + 1)'(KEEP));
   assign wr_entry.task_id     = in_data_ff.task_id;
   assign wr_entry.order       = in_data_ff.alloc_order;
   assign wr_entry.seconds     = in_data_ff.time_seconds;
   assign wr_entry.nanoseconds = in_data_ff.time_nanoseconds;
   assign wr_entry.wait_ms     = in_data_ff.wait_ms;

   awlm_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr),
      .wr_idx  (slot_in[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_sel  (in_data_ff.select),
      .rd_data (rd_entry)
   );

   // statistic read
   logic [31:0]    stat_sel;
   class_stat_type cls;
   logic [1:0]     cls_idx;

   assign cls_idx = in_data_ff.select[3:2];
   assign cls     = stat[(cls_idx == 2'd3) ? 2'd0 : cls_idx];

   always_comb begin
      if (in_data_ff.select == SEL_COUNTER) begin
         stat_sel = counter_ff;
      end else if (cls_idx == 2'd3) begin
         stat_sel = '0;
      end else begin
         case (in_data_ff.select[1:0])
            STAT_MAX_WAIT:   stat_sel = cls.max_wait;
            STAT_MAX_ORDER:  stat_sel = 32'(cls.max_order);
            STAT_HIGH_COUNT: stat_sel = cls.high_count;
            default:         stat_sel = cls.low_count;
         endcase
      end
   end

   // result assembly
   always_comb begin
      rsp_data_in = '0;
      case (in_cmd_ff)
         CMD_WAIT: begin
            if (enable_ff) begin
               rsp_data_in.log_alert     = is_high && log_enable_ff
                                           && (in_data_ff.wait_ms >= log_th_ff);
               rsp_data_in.trigger_alert = is_high && trig_enable_ff
                                           && (in_data_ff.wait_ms >= trig_th_ff);
               rsp_data_in.recorded      = is_low;
               rsp_data_in.record_slot   = is_low ? 4'(slot_in) : 4'd0;
            end
         end
         CMD_READ_STAT: begin
            rsp_data_in.stat_value = stat_sel;
         end
         CMD_READ_RING: begin
            rsp_data_in.rec_task_id     = rd_entry.task_id;
            rsp_data_in.rec_order       = rd_entry.order;
            rsp_data_in.rec_seconds     = rd_entry.seconds;
            rsp_data_in.rec_nanoseconds = rd_entry.nanoseconds;
            rsp_data_in.rec_wait_ms     = rd_entry.wait_ms;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   // checks
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (SLOT_W + 1)'(slot_ff) < (SLOT_W + 1)'(RING_DEPTH))
      else $error("ring slot beyond depth");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> counter_ff == $past(counter_ff) + 32'($past(do_record)))
      else $error("record counter moved without a record");

   a_all_high: assert property (@(posedge clock) disable iff (reset)
      do_event && is_high |=> stat[2].high_count == $past(stat[2].high_count) + 32'd1)
      else $error("high wait not counted in all class");

   a_record_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.recorded |-> rsp_data_ff.stat_value == '0
         && rsp_data_ff.rec_wait_ms == '0)
      else $error("recorded item carries read data");

endmodule

`default_nettype wire

// ===== rtl/awlm_class.sv =====
// Statistics of one wait class: longest wait, its order, high and low counts.
// Depends on awlm_pkg.
`default_nettype none

module awlm_class (
   input  wire                      clock,
   input  wire                      reset,
   input  awlm_pkg::class_upd_type  upd,
   output awlm_pkg::class_stat_type stat
);
   import awlm_pkg::*;

   logic [31:0] max_wait_ff, high_count_ff, low_count_ff;
   logic [3:0]  max_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wait_ff   <= '0;
         max_order_ff  <= '0;
         high_count_ff <= '0;
         low_count_ff  <= '0;
      end else if (upd.update) begin
         if (upd.wait_ms > max_wait_ff) begin
            max_wait_ff  <= upd.wait_ms;
            max_order_ff <= upd.order;
         end
         // high takes precedence even when low threshold sits above high
         if (upd.is_high) begin
            high_count_ff <= high_count_ff + 32'd1;
         end else if (upd.is_low) begin
            low_count_ff <= low_count_ff + 32'd1;
         end
      end
   end

   assign stat.max_wait   = max_wait_ff;
   assign stat.max_order  = max_order_ff;
   assign stat.high_count = high_count_ff;
   assign stat.low_count  = low_count_ff;

endmodule

`default_nettype wire

// ===== rtl/awlm_ring.sv =====
// Record ring of the monitor. Only slots reachable by the 4-bit select are
// kept; per-slot valid bits make an unwritten slot read as zero.
// Depends on awlm_pkg.
`default_nettype none

module awlm_ring #(
   parameter int RING_DEPTH = 16,
   parameter int KEEP       = (RING_DEPTH < 16) ? RING_DEPTH : 16,
   parameter int IDX_W      = $clog2(KEEP)
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      wr_en,
   input  wire  [IDX_W-1:0]         wr_idx,
   input  awlm_pkg::ring_entry_type wr_data,
   input  wire  [3:0]               rd_sel,
   output awlm_pkg::ring_entry_type rd_data
);
   import awlm_pkg::*;

   ring_entry_type         entry_ff [KEEP];
   logic [KEEP-1:0]        valid_ff;
   logic [IDX_W-1:0]       rd_idx;
   logic                   rd_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_idx = rd_sel[IDX_W-1:0];
   assign rd_hit = ({1'b0, rd_sel} < 5'(KEEP)) && valid_ff[rd_idx];
   assign rd_data = rd_hit ? entry_ff[rd_idx] : '0;

endmodule

`default_nettype wire

// ===== tb/alloc_wait_latency_monitor_core_test.sv =====
// Self-checking test of alloc_wait_latency_monitor_core: random and directed items on the
// req stream, results checked against a wait-statistics predictor kept in a scoreboard class.
// Depends on awlm_pkg and the alloc_wait_latency_monitor_core RTL.
`default_nettype none

module alloc_wait_latency_monitor_core_test;
   import awlm_pkg::*;

   localparam int RING_SLOTS  = 16;
   localparam int LONG_HOLD   = 60;
   localparam int CYCLE_LIMIT = 200000;

   // predicted ring, statistics and the results they lead to
   class wait_stats_board;
      logic        enable_on, log_on, trig_on;
      logic [31:0] high_ms, low_ms, log_ms, trig_ms;
      logic [31:0] max_wait [NUM_CLASS];
      logic [3:0]  max_order [NUM_CLASS];
      logic [31:0] high_hits [NUM_CLASS];
      logic [31:0] low_cnt [NUM_CLASS];
      logic [31:0] rec_count;
      ring_entry_type ring [RING_SLOTS];
      rsp_data_type due_results [$];
      int errors, items, waits, records, alerts, reads;

      function new();
         enable_on = 1'b0;
         log_on    = 1'b0;
         trig_on   = 1'b0;
         high_ms   = HIGH_THRESH_RESET;
         low_ms    = LOW_THRESH_RESET;
         log_ms    = LOG_THRESH_RESET;
         trig_ms   = TRIG_THRESH_RESET;
         rec_count = '0;
         for (int c = 0; c < NUM_CLASS; c++) begin
            max_wait[c]  = '0;
            max_order[c] = '0;
            high_hits[c] = '0;
            low_cnt[c]   = '0;
         end
         for (int s = 0; s < RING_SLOTS; s++) ring[s] = '0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
         case (idx)
            REG_ENABLE:      enable_on = val[0];
            REG_LOG_ENABLE:  log_on    = val[0];
            REG_TRIG_ENABLE: trig_on   = val[0];
            REG_HIGH_THRESH: high_ms   = val;
            REG_LOW_THRESH:  low_ms    = val;
            REG_LOG_THRESH:  log_ms    = val;
            REG_TRIG_THRESH: trig_ms   = val;
            default: ;
         endcase
      endfunction

      function void bump_class(int c, logic [31:0] w, logic [3:0] ord);
         if (w > max_wait[c]) begin
            max_wait[c]  = w;
            max_order[c] = ord;
         end
         if (w >= high_ms) high_hits[c] = high_hits[c] + 32'd1;
         else if (w >= low_ms) low_cnt[c] = low_cnt[c] + 32'd1;
      endfunction

      function logic [31:0] stat_of(logic [3:0] sel);
         int c;
         c = int'(sel[3:2]);
         if (sel == SEL_COUNTER) return rec_count;
         if (c > 2) return '0;
         case (sel[1:0])
            STAT_MAX_WAIT:   return max_wait[c];
            STAT_MAX_ORDER:  return {28'd0, max_order[c]};
            STAT_HIGH_COUNT: return high_hits[c];
            default:         return low_cnt[c];
         endcase
      endfunction

      function void note_request(logic [1:0] cmd, req_data_type d);
         rsp_data_type r;
         int unsigned  slot;
         r = '0;
         items++;
         case (cmd)
            CMD_WAIT: begin
               waits++;
               if (enable_on) begin
                  if (d.is_urgent) bump_class(0, d.wait_ms, d.alloc_order);
                  if (d.is_foreground) bump_class(1, d.wait_ms, d.alloc_order);
                  bump_class(2, d.wait_ms, d.alloc_order);
                  // alerts only for a high wait
                  if (d.wait_ms >= high_ms) begin
                     r.log_alert     = log_on && (d.wait_ms >= log_ms);
                     r.trigger_alert = trig_on && (d.wait_ms >= trig_ms);
                  end
                  if (d.wait_ms >= low_ms) begin
                     rec_count = rec_count + 32'd1;   // counter moves before the slot is chosen
                     slot = rec_count % RING_SLOTS;
                     ring[slot] = '{task_id: d.task_id, order: d.alloc_order,
                                    seconds: d.time_seconds,
                                    nanoseconds: d.time_nanoseconds, wait_ms: d.wait_ms};
                     r.recorded    = 1'b1;
                     r.record_slot = slot[3:0];
                     records++;
                  end
                  if (r.log_alert || r.trigger_alert) alerts++;
               end
            end
            CMD_READ_STAT: begin
               reads++;
               r.stat_value = stat_of(d.select);
            end
            CMD_READ_RING: begin
               reads++;
               r.rec_task_id     = ring[d.select].task_id;
               r.rec_order       = ring[d.select].order;
               r.rec_seconds     = ring[d.select].seconds;
               r.rec_nanoseconds = ring[d.select].nanoseconds;
               r.rec_wait_ms     = ring[d.select].wait_ms;
            end
            default: ;
         endcase
         due_results.push_back(r);
      endfunction

      function void match_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_data_type got);
         rsp_data_type want;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item, expected none, actual 0x%0h", $time, got);
            return;
         end
         want = due_results.pop_front();
         match_field("log_alert", 32'(want.log_alert), 32'(got.log_alert));
         match_field("trigger_alert", 32'(want.trigger_alert), 32'(got.trigger_alert));
         match_field("recorded", 32'(want.recorded), 32'(got.recorded));
         match_field("record_slot", 32'(want.record_slot), 32'(got.record_slot));
         match_field("stat_value", want.stat_value, got.stat_value);
         match_field("rec_task_id", 32'(want.rec_task_id), 32'(got.rec_task_id));
         match_field("rec_order", 32'(want.rec_order), 32'(got.rec_order));
         match_field("rec_seconds", want.rec_seconds, got.rec_seconds);
         match_field("rec_nanoseconds", 32'(want.rec_nanoseconds),
                     32'(got.rec_nanoseconds));
         match_field("rec_wait_ms", want.rec_wait_ms, got.rec_wait_ms);
      endfunction

      function int pending_count();
         return due_results.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   wait_stats_board board = new;
   bit  idle_on      = 1'b1;
   bit  hold_request = 1'b0;
   int  cycles       = 0;
   int  settings     = 0;

   alloc_wait_latency_monitor_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, board.pending_count());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (int held = 0; held < LONG_HOLD; held++) @(negedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_data_type'(rsp_tdata));
   end

   task automatic send_item(input logic [1:0] cmd, input req_data_type d);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, d);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_count() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      board.set_reg(idx, val);
   endtask

   task automatic apply_setting(input bit en, input bit log_en, input bit trig_en,
                                input logic [31:0] high, input logic [31:0] low,
                                input logic [31:0] logt, input logic [31:0] trigt);
      drain();
      write_reg(REG_ENABLE, {31'd0, en});
      write_reg(REG_LOG_ENABLE, {31'd0, log_en});
      write_reg(REG_TRIG_ENABLE, {31'd0, trig_en});
      write_reg(REG_HIGH_THRESH, high);
      write_reg(REG_LOW_THRESH, low);
      write_reg(REG_LOG_THRESH, logt);
      write_reg(REG_TRIG_THRESH, trigt);
      settings++;
   endtask

   // waits cluster around the active thresholds so every compare flips both ways
   function automatic logic [31:0] pick_wait();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return board.high_ms + $urandom_range(0, 2) - 1;
         3: return board.low_ms + $urandom_range(0, 2) - 1;
         4: return board.log_ms + $urandom_range(0, 2) - 1;
         5: return board.trig_ms + $urandom_range(0, 2) - 1;
         6: return $urandom;
         default: return $urandom_range(0, 20000);
      endcase
   endfunction

   function automatic req_data_type make_item(input logic [31:0] w, input logic [3:0] sel);
      req_data_type d;
      d                  = '0;
      d.wait_ms          = w;
      d.alloc_order      = 4'($urandom_range(0, 15));
      d.is_urgent        = 1'($urandom_range(0, 1));
      d.is_foreground    = 1'($urandom_range(0, 1));
      d.task_id          = 22'($urandom_range(0, 22'h3F_FFFF));
      d.time_seconds     = $urandom;
      d.time_nanoseconds = 30'($urandom_range(0, 999999999));
      d.select           = sel;
      return d;
   endfunction

   task automatic run_random(input int count);
      int          pick;
      logic [1:0]  cmd;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) cmd = CMD_WAIT;
         else if (pick < 80) cmd = CMD_READ_STAT;
         else if (pick < 95) cmd = CMD_READ_RING;
         else cmd = 2'd3;
         send_item(cmd, make_item(pick_wait(), 4'($urandom_range(0, 15))));
      end
   endtask

   initial begin
      logic [31:0] edge_waits [7];
      req_data_type d;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled monitor: wait event is ignored, unused command gives zeros
      send_item(CMD_WAIT, make_item(32'hFFFF_FFFF, 4'd0));
      send_item(CMD_READ_STAT, make_item(32'd0, SEL_COUNTER));
      send_item(CMD_READ_RING, make_item(32'd0, 4'd1));
      send_item(2'd3, make_item(32'hFFFF_FFFF, 4'd15));

      apply_setting(1'b1, 1'b1, 1'b1, HIGH_THRESH_RESET, LOW_THRESH_RESET,
                    LOG_THRESH_RESET, TRIG_THRESH_RESET);
      edge_waits = '{32'd99, 32'd100, 32'd499, 32'd500, 32'd1000, 32'd10000, 32'hFFFF_FFFF};
      foreach (edge_waits[i]) begin
         d = make_item(edge_waits[i], 4'd0);
         d.is_urgent     = i[0];
         d.is_foreground = i[1];
         d.alloc_order   = (i == 6) ? 4'd15 : i[3:0];
         send_item(CMD_WAIT, d);
      end
      for (int s = 0; s < 16; s++) send_item(CMD_READ_STAT, make_item(32'd0, s[3:0]));
      send_item(CMD_READ_RING, make_item(32'd0, 4'd1));
      send_item(CMD_READ_RING, make_item(32'd0, 4'd15));

      run_random(200);

      // zero thresholds: every wait is high, recorded and logged; receiver holds off
      apply_setting(1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0);
      hold_request = 1'b1;
      run_random(200);

      // all thresholds at the top
      apply_setting(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(150);

      // low above high, log threshold below high, trigger threshold between high and low
      apply_setting(1'b1, 1'b1, 1'b1, 32'd300, 32'd800, 32'd200, 32'd600);
      run_random(200);

      // monitor off again
      apply_setting(1'b0, 1'b1, 1'b1, 32'd500, 32'd100, 32'd1000, 32'd10000);
      run_random(100);

      apply_setting(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(200, 2000), $urandom_range(0, 1500),
                    $urandom_range(0, 4000), $urandom_range(0, 6000));
      run_random(150);

      // final stretch runs at full rate on both sides
      idle_on = 1'b0;
      run_random(150);

      drain();
      repeat (10) @(posedge clock);
      if (board.pending_count() != 0) begin
         board.errors++;
         $display("%0t: %0d expected results never arrived", $time, board.pending_count());
      end
      $display("Ran %0d items over %0d register settings: %0d wait events, %0d recorded,",
               board.items, settings, board.waits, board.records);
      $display("%0d with alerts, %0d statistic and ring reads, %0d errors",
               board.alerts, board.reads, board.errors);
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/awlm_pkg.sv
rtl/awlm_class.sv
rtl/awlm_ring.sv
rtl/alloc_wait_latency_monitor_core.sv
tb/alloc_wait_latency_monitor_core_test.sv
